### rtl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell for one accepted word
    typedef struct packed {
        logic ins;   // load at key, cells above take left neighbor
        logic app;   // load at key only
        logic del;   // cells at and above key take right neighbor
        logic rd;    // capture entry at key
        logic cap;   // word accepted this cycle
    } cell_ctrl_t;

endpackage

### rtl/positional_insert_delete_list_unit.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Ordered list of up to DEPTH signed words with positional insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on the s_ stream channel; each gives exactly one
//   result word on the m_ channel, in order.
//   The list is a row of DEPTH cells; insert and delete shift every cell
//   above the target position by one slot in the same cycle.
//   Throughput: one command word per cycle, sustained, when m_tready is high.
//   Pipeline: each result moves from the p1 stage to the output register;
//   a read captures the selected cell on acceptance, and all cells are
//   merged into the output register when the p1 stage advances.
//   Stall: if m_tready is low, one result waits in the output register and
//   one more in the merge stage; then s_tready drops until space frees up.
//   Reset: aresetn (synchronous, active low) empties the list and drops all
//   pending results. Cell contents are not cleared; only slots below the
//   entry count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] cmd, [9:3] position, [41:10] element_value, [47:42] zero
    input  logic [pidl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [8:2] entry_total, [40:9] read_value, [47:41] zero
    output logic [pidl_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pidl_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               p1_valid_reg, p1_valid_next;
    status_t            p1_status_reg, p1_status_next;
    logic [CNT_W-1:0]   p1_total_reg, p1_total_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [CNT_W-1:0]   m_total_reg, m_total_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;

    logic               accept, p1_adv;
    cmd_t               cmd;
    logic [KEY_W-1:0]   pos_k, cnt_k, key;
    logic               full, bad_pos;
    status_t            status;
    cell_ctrl_t         ctrl;
    logic [VALUE_W-1:0] value;

    logic [VALUE_W-1:0] data_w [DEPTH];
    logic [VALUE_W-1:0] rd_w   [DEPTH];
    logic [DEPTH-1:0]   rd_col [VALUE_W];
    logic [VALUE_W-1:0] rd_merge;

    assign cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
    assign pos_k = KEY_W'(s_tdata[CMD_W +: POS_W]);
    assign value = s_tdata[CMD_W+POS_W +: VALUE_W];
    assign cnt_k = KEY_W'(count_reg);
    assign full  = (count_reg == CNT_W'(DEPTH));

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctrl       = '0;
        ctrl.cap   = accept;
        count_next = count_reg;
        status     = ST_OK;
        key        = pos_k - KEY_W'(1);
        bad_pos    = (pos_k == '0) || (pos_k > cnt_k);
        unique case (cmd)
            CMD_CLEAR: begin
                count_next = '0;
            end
            CMD_APPEND: begin
                key = cnt_k;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.app   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else if ((pos_k == '0) || (pos_k > cnt_k + KEY_W'(1))) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.ins   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (bad_pos) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.del   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (bad_pos) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.rd = 1'b1;
                end
            end
            default: begin
                status = ST_RANGE;
            end
        endcase
        if (!accept) begin
            ctrl       = '0;
            count_next = count_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [VALUE_W-1:0] left_d, right_d;
            if (gi == 0) begin : g_first
                assign left_d = value;
            end else begin : g_left
                assign left_d = data_w[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_d = data_w[gi];
            end else begin : g_right
                assign right_d = data_w[gi+1];
            end
            pidl_cell #(
                .KEY_W (KEY_W),
                .IDX   (gi)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .key      (key),
                .value    (value),
                .left_in  (left_d),
                .right_in (right_d),
                .data_out (data_w[gi]),
                .rd_out   (rd_w[gi])
            );
        end
    endgenerate

    // only the selected cell can hold a nonzero read word
    always_comb begin
        for (int b = 0; b < VALUE_W; b++) begin
            for (int c = 0; c < DEPTH; c++) begin
                rd_col[b][c] = rd_w[c][b];
            end
            rd_merge[b] = |rd_col[b];
        end
    end

    always_comb begin
        p1_valid_next  = p1_valid_reg;
        p1_status_next = p1_status_reg;
        p1_total_next  = p1_total_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_total_next   = m_total_reg;
        m_value_next   = m_value_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (p1_adv) begin
            m_valid_next  = 1'b1;
            m_status_next = p1_status_reg;
            m_total_next  = p1_total_reg;
            m_value_next  = rd_merge;
            p1_valid_next = 1'b0;
        end
        if (accept) begin
            p1_valid_next  = 1'b1;
            p1_status_next = status;
            p1_total_next  = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        p1_status_reg <= p1_status_next;
        p1_total_reg  <= p1_total_next;
        m_status_reg  <= m_status_next;
        m_total_reg   <= m_total_next;
        m_value_reg   <= m_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-STAT_W-TOTAL_W-VALUE_W)'(0), m_value_reg,
                       TOTAL_W'(m_total_reg), m_status_reg};

endmodule

### rtl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds an entry, shifts to or from its neighbors, and
// captures its entry for a read when selected.
// ----------------------------------------------------------------------------
module pidl_cell #(
    parameter int KEY_W = 8,
    parameter int IDX   = 0
) (
    input  logic                          aclk,
    input  pidl_pkg::cell_ctrl_t          ctrl,
    input  logic [KEY_W-1:0]              key,
    input  logic [pidl_pkg::VALUE_W-1:0]  value,
    input  logic [pidl_pkg::VALUE_W-1:0]  left_in,
    input  logic [pidl_pkg::VALUE_W-1:0]  right_in,
    output logic [pidl_pkg::VALUE_W-1:0]  data_out,
    output logic [pidl_pkg::VALUE_W-1:0]  rd_out
);
    import pidl_pkg::*;

    logic [VALUE_W-1:0] data_reg, data_next;
    logic [VALUE_W-1:0] rd_reg,   rd_next;
    logic               hit, above;

    assign hit   = (KEY_W'(IDX) == key);
    assign above = (KEY_W'(IDX) >  key);

    always_comb begin
        data_next = data_reg;
        if ((ctrl.ins || ctrl.app) && hit) begin
            data_next = value;
        end else if (ctrl.ins && above) begin
            data_next = left_in;
        end else if (ctrl.del && (hit || above)) begin
            data_next = right_in;
        end
        rd_next = rd_reg;
        if (ctrl.cap) begin
            rd_next = (ctrl.rd && hit) ? data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data_out = data_reg;
    assign rd_out   = rd_reg;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for positional_insert_delete_list_unit: command words
// (clear, append, insert, delete, read, unused codes) go in on the s_ stream.
// A list model inside the bench predicts status, count and read value.
// Each result word is checked in order against those predictions, under
// random backpressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import pidl_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int POS_MAX    = (1 << POS_W) - 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [CMD_W-1:0]   cmd;
    } list_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TOTAL_W-1:0] total;
        logic [STAT_W-1:0]  status;
    } list_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    list_cmd_t      pending_cmds[$];
    list_result_t   expected_results[$];
    list_cmd_t      offered_cmd;

    logic [VALUE_W-1:0] list_mem[LIST_DEPTH];
    int             list_len = 0;

    int             gen_len  = 0;
    bit             gen_grow = 1'b1;

    int             send_idle_pct = 14;
    int             recv_idle_pct = 82;
    bit             hold_req   = 1'b0;
    bit             hold_taken = 1'b0;
    int             hold_left  = 0;
    int             error_count = 0;

    positional_insert_delete_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // list model: apply one accepted word, queue the result it should give
    task automatic apply_list_cmd(input list_cmd_t c);
        list_result_t r;
        int p;
        p = c.pos;
        r.status = ST_OK;
        r.value  = '0;
        case (c.cmd)
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = c.value;
                    list_len++;
                end
            end
            CMD_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (p == 0 || p > list_len + 1) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = list_len; i >= p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = c.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (p == 0 || p > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = p - 1; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (p == 0 || p > list_len)
                    r.status = ST_RANGE;
                else
                    r.value = list_mem[p-1];
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.total = TOTAL_W'(list_len);
        expected_results.push_back(r);
    endtask

    // stimulus side keeps only the entry count, to aim positions
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic [VALUE_W-1:0] value);
        list_cmd_t c;
        c.cmd   = cmd;
        c.pos   = POS_W'(pos);
        c.value = value;
        case (cmd)
            CMD_CLEAR:  gen_len = 0;
            CMD_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
            CMD_INSERT: if (gen_len < LIST_DEPTH && pos >= 1 && pos <= gen_len + 1) gen_len++;
            CMD_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
            default: ;
        endcase
        pending_cmds.push_back(c);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // lim is the highest legal position; 0 means none is legal
    function automatic int pick_pos(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 0;
        if (r < 12)
            return $urandom_range(POS_MAX);
        if (r < 18 || lim == 0)
            return (lim + 1 > POS_MAX) ? POS_MAX : lim + 1;
        return $urandom_range(lim, 1);
    endfunction

    // grow toward full, then shrink toward empty, over and over
    task automatic queue_random_cmds(input int n);
        int r;
        logic [CMD_W-1:0] cmd;
        for (int k = 0; k < n; k++) begin
            if (gen_len == LIST_DEPTH && $urandom_range(7) == 0)
                gen_grow = 1'b0;
            if (gen_len == 0 && $urandom_range(3) == 0)
                gen_grow = 1'b1;
            r = $urandom_range(99);
            if (r < 3) begin
                queue_cmd(CMD_W'($urandom_range(7, 5)), $urandom_range(POS_MAX), pick_value());
            end else if (!gen_grow && r < 6) begin
                queue_cmd(CMD_CLEAR, pick_pos(gen_len), pick_value());
            end else begin
                r = $urandom_range(99);
                if (gen_grow)
                    cmd = (r < 40) ? CMD_APPEND : (r < 75) ? CMD_INSERT :
                          (r < 85) ? CMD_DELETE : CMD_READ;
                else
                    cmd = (r < 10) ? CMD_APPEND : (r < 20) ? CMD_INSERT :
                          (r < 60) ? CMD_DELETE : CMD_READ;
                queue_cmd(cmd, pick_pos(cmd == CMD_INSERT ? gen_len + 1 : gen_len),
                          pick_value());
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                apply_list_cmd(offered_cmd);
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(offered_cmd);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(list_result_t)-1:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (got.total !== want.total) begin
                    $display("%0t: entry_total expected %0d got %0d",
                             $time, want.total, got.total);
                    error_count++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: read_value expected %h got %h", $time, want.value, got.value);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty list, bounds, extremes, unused codes
        queue_cmd(CMD_CLEAR,  0,   32'h0);
        queue_cmd(CMD_READ,   1,   32'h0);
        queue_cmd(CMD_DELETE, 1,   32'h0);
        queue_cmd(CMD_INSERT, 0,   32'h1234_5678);
        queue_cmd(CMD_INSERT, 2,   32'h1234_5678);
        queue_cmd(CMD_INSERT, 1,   32'h8000_0000);
        queue_cmd(CMD_APPEND, 0,   32'h7fff_ffff);
        queue_cmd(CMD_APPEND, 127, 32'hffff_ffff);
        queue_cmd(CMD_INSERT, 4,   32'h0000_0000);
        queue_cmd(CMD_INSERT, 2,   32'h5a5a_a5a5);
        queue_cmd(CMD_READ,   1,   32'h0);
        queue_cmd(CMD_READ,   5,   32'h0);
        queue_cmd(CMD_READ,   0,   32'h0);
        queue_cmd(CMD_READ,   6,   32'h0);
        queue_cmd(CMD_READ,   127, 32'hffff_ffff);
        queue_cmd(CMD_INSERT, 64,  32'h0000_0001);
        queue_cmd(CMD_DELETE, 0,   32'h0);
        queue_cmd(CMD_DELETE, 6,   32'h0);
        queue_cmd(CMD_DELETE, 1,   32'h0);
        queue_cmd(CMD_DELETE, 4,   32'h0);
        queue_cmd(3'd5,       127, 32'hffff_ffff);
        queue_cmd(3'd6,       0,   32'h0);
        queue_cmd(3'd7,       64,  32'hffff_ffff);
        queue_cmd(CMD_READ,   3,   32'h0);
        queue_cmd(CMD_CLEAR,  127, 32'hffff_ffff);

        queue_random_cmds(350);
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct = 14;
        queue_random_cmds(350);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        queue_random_cmds(375);
        wait_drained();

        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
